>>> rtl/drct_pkg.sv
// shared types and constants of the descriptor ring completion tracker
package drct_pkg;

	localparam int RING_DEPTH_DEF = 256;

	localparam logic CMD_DONE_WRITE = 1'b0;
	localparam logic CMD_INTERRUPT  = 1'b1;

	localparam logic RING_RX = 1'b0;
	localparam logic RING_TX = 1'b1;

	localparam logic [31:0] CAUSE_TX_WRITEBACK = 32'h0000_0001;
	localparam logic [31:0] CAUSE_TX_QEMPTY    = 32'h0000_0002;
	localparam logic [31:0] CAUSE_LINK         = 32'h0000_0004;
	localparam logic [31:0] CAUSE_RX_SEQERR    = 32'h0000_0008;
	localparam logic [31:0] CAUSE_RX_THRESH    = 32'h0000_0010;
	localparam logic [31:0] CAUSE_RX_OVERRUN   = 32'h0000_0040;
	localparam logic [31:0] CAUSE_RX_TIMER     = 32'h0000_0080;
	localparam logic [31:0] CAUSE_RX_SMALL     = 32'h0001_0000;

	localparam logic [31:0] RX_CAUSES = CAUSE_RX_SEQERR | CAUSE_RX_THRESH | CAUSE_RX_OVERRUN
		| CAUSE_RX_TIMER | CAUSE_RX_SMALL;
	localparam logic [31:0] TX_CAUSES = CAUSE_TX_WRITEBACK | CAUSE_TX_QEMPTY;

	localparam logic [8:0] SIG_MAX = 9'h1FF;

	// write side of the done-bit store
	typedef struct packed {
		logic en;
		logic both;
		logic ring;
		logic data;
	} mem_wr_t;

	// walk request from the sequencer
	typedef struct packed {
		logic       start;
		logic       ring;
		logic [7:0] hw;
	} walk_req_t;

	// walk status back to the sequencer
	typedef struct packed {
		logic busy;
		logic finish;
		logic overrun;
	} walk_sts_t;

endpackage

>>> rtl/drct_done_mem.sv
// done-bit store of both rings, synchronous read with registered read data
module drct_done_mem import drct_pkg::*; #(
	parameter int DEPTH = RING_DEPTH_DEF,
	localparam int PW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  mem_wr_t       wr,
	input  logic [PW-1:0] wr_addr,
	input  logic [PW-1:0] rd_addr,
	output logic [1:0]    rd_data
);

	logic rx_mem [DEPTH];
	logic tx_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			if (wr.both || wr.ring == RING_RX) begin
				rx_mem[wr_addr] <= wr.data;
			end
			if (wr.both || wr.ring == RING_TX) begin
				tx_mem[wr_addr] <= wr.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= {tx_mem[rd_addr], rx_mem[rd_addr]};
	end

endmodule

>>> rtl/drct_walk_unit.sv
// ring walker: one descriptor per cycle with the next read issued ahead
module drct_walk_unit import drct_pkg::*; #(
	parameter int DEPTH = RING_DEPTH_DEF,
	localparam int PW = $clog2(DEPTH),
	localparam int SW = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  walk_req_t     req,
	input  logic [PW-1:0] start_pos,
	input  logic [1:0]    rd_data,
	output logic [PW-1:0] rd_addr,
	output walk_sts_t     sts,
	output logic [PW-1:0] end_pos,
	output logic [SW-1:0] steps
);

	localparam int CW = (PW > 8) ? PW : 8;

	logic          busy_q;
	logic          ring_q;
	logic          met_q;
	logic [7:0]    hw_q;
	logic [PW-1:0] pos_q;
	logic [SW-1:0] steps_q;

	logic          met_now;
	logic          stop;
	logic          limit;
	logic          finish;
	logic [PW-1:0] pos_inc;

	assign pos_inc = (pos_q == PW'(DEPTH - 1)) ? '0 : pos_q + PW'(1);
	// a hardware position beyond the ring never matches
	assign met_now = met_q || (CW'(pos_q) == CW'(hw_q));
	assign stop    = met_now && !rd_data[ring_q];
	assign limit   = !stop && (steps_q == SW'(DEPTH));
	assign finish  = busy_q && (stop || limit);

	assign rd_addr = req.start ? start_pos : pos_inc;

	assign sts.busy    = busy_q;
	assign sts.finish  = finish;
	assign sts.overrun = busy_q && limit;
	assign end_pos     = pos_q;
	assign steps       = steps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (finish) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ring_q  <= req.ring;
			hw_q    <= req.hw;
			met_q   <= 1'b0;
			pos_q   <= start_pos;
			steps_q <= '0;
		end else if (busy_q && !finish) begin
			met_q   <= met_now;
			pos_q   <= pos_inc;
			steps_q <= steps_q + SW'(1);
		end
	end

`ifndef ASSERT_OFF
	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (steps_q <= SW'(DEPTH)))
		else $error("walk step count beyond ring depth");

	a_step_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !finish && !req.start) |=> (steps_q == $past(steps_q) + SW'(1)))
		else $error("walk did not advance by one step");
`endif

endmodule

>>> rtl/descriptor_ring_completion_tracker_unit.sv
// descriptor ring completion tracker: sequencer, output register, walker and store
// a done-bit write gives its result in the cycle after the transfer; an interrupt gives
//   its result after the selected ring walks, RX first, through ST_HOLD to the output
// one interrupt at a time, walked one descriptor per memory read; a write needs output room
// reset: a clearing pass over all RING_DEPTH slots zeroes the done-bit store; no input
//   is taken until it ends, walk positions reset to zero
module descriptor_ring_completion_tracker_unit import drct_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic        ring_select,
	input  logic [7:0]  slot,
	input  logic        done_value,
	input  logic [31:0] cause_word,
	input  logic [7:0]  rx_hw_position,
	input  logic [7:0]  tx_hw_position,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        handled,
	output logic        link_changed,
	output logic [8:0]  rx_signals,
	output logic [8:0]  tx_signals,
	output logic [7:0]  rx_walk_out,
	output logic [7:0]  tx_walk_out,
	output logic        walk_overrun
);

	localparam int PW = $clog2(RING_DEPTH);
	localparam int SW = $clog2(RING_DEPTH + 1);
	localparam int CW = (PW > 8) ? PW : 8;
	localparam int XW = (SW > 9) ? SW : 9;

	typedef enum logic [4:0] {
		ST_CLEAR   = 5'b00001,
		ST_IDLE    = 5'b00010,
		ST_RX_WALK = 5'b00100,
		ST_TX_WALK = 5'b01000,
		ST_HOLD    = 5'b10000
	} state_t;

	state_t        st_q, st_d;
	logic [PW-1:0] clr_q;
	logic [PW-1:0] rx_walk_q, tx_walk_q;
	logic          handled_q, link_q, over_q, tx_sel_q;
	logic [7:0]    tx_hw_q;
	logic [8:0]    rx_sig_q, tx_sig_q;

	logic          out_valid_q;
	logic          out_handled_q, out_link_q, out_over_q;
	logic [8:0]    out_rx_sig_q, out_tx_sig_q;
	logic [PW-1:0] out_rx_walk_q, out_tx_walk_q;

	logic          in_acc;
	logic          out_room;
	logic          is_int;
	logic          rx_sel_in, tx_sel_in;
	logic          slot_ok;
	logic          start_rx, start_tx_now, start_tx_after;
	logic          load_write, load_hold;
	logic [8:0]    walk_sig;
	logic [XW-1:0] steps_ext;

	mem_wr_t       mem_wr;
	logic [PW-1:0] mem_wr_addr;
	logic [PW-1:0] mem_rd_addr;
	logic [1:0]    mem_rd_data;

	walk_req_t     wreq;
	walk_sts_t     wsts;
	logic [PW-1:0] wstart_pos;
	logic [PW-1:0] wend_pos;
	logic [SW-1:0] wsteps;

	assign out_room  = !out_valid_q || out_ready;
	assign is_int    = (cmd == CMD_INTERRUPT);
	assign in_ready  = (st_q == ST_IDLE) && (is_int || out_room);
	assign in_acc    = in_valid && in_ready;
	assign rx_sel_in = |(cause_word & RX_CAUSES);
	assign tx_sel_in = |(cause_word & TX_CAUSES);
	assign slot_ok   = (XW'(slot) < XW'(RING_DEPTH));

	assign start_rx       = in_acc && is_int && rx_sel_in;
	assign start_tx_now   = in_acc && is_int && !rx_sel_in && tx_sel_in;
	assign start_tx_after = (st_q == ST_RX_WALK) && wsts.finish && tx_sel_q;

	assign load_write = in_acc && !is_int;
	assign load_hold  = (st_q == ST_HOLD) && out_room;

	assign wreq.start = start_rx || start_tx_now || start_tx_after;
	assign wreq.ring  = start_rx ? RING_RX : RING_TX;
	assign wreq.hw    = start_rx ? rx_hw_position : (start_tx_now ? tx_hw_position : tx_hw_q);
	assign wstart_pos = start_rx ? rx_walk_q : tx_walk_q;

	// counts above the 9-bit field saturate
	assign steps_ext = XW'(wsteps);
	assign walk_sig  = (steps_ext > XW'(SIG_MAX)) ? SIG_MAX : steps_ext[8:0];

	always_comb begin
		mem_wr      = '0;
		mem_wr_addr = clr_q;
		if (st_q == ST_CLEAR) begin
			mem_wr.en   = 1'b1;
			mem_wr.both = 1'b1;
		end else if (load_write && slot_ok) begin
			mem_wr.en   = 1'b1;
			mem_wr.ring = ring_select;
			mem_wr.data = done_value;
			mem_wr_addr = PW'(slot);
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_CLEAR: begin
				if (clr_q == PW'(RING_DEPTH - 1)) begin
					st_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_acc && is_int) begin
					if (rx_sel_in) begin
						st_d = ST_RX_WALK;
					end else if (tx_sel_in) begin
						st_d = ST_TX_WALK;
					end else begin
						st_d = ST_HOLD;
					end
				end
			end
			ST_RX_WALK: begin
				if (wsts.finish) begin
					st_d = tx_sel_q ? ST_TX_WALK : ST_HOLD;
				end
			end
			ST_TX_WALK: begin
				if (wsts.finish) begin
					st_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_room) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			clr_q       <= '0;
			rx_walk_q   <= '0;
			tx_walk_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_CLEAR) begin
				clr_q <= clr_q + PW'(1);
			end
			if (wsts.finish) begin
				if (st_q == ST_RX_WALK) begin
					rx_walk_q <= wend_pos;
				end else begin
					tx_walk_q <= wend_pos;
				end
			end
			if (load_write || load_hold) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// interrupt bookkeeping while the walks run
	always_ff @(posedge clk) begin
		if (in_acc && is_int) begin
			handled_q <= (cause_word != 32'h0);
			link_q    <= |(cause_word & CAUSE_LINK);
			tx_sel_q  <= tx_sel_in;
			tx_hw_q   <= tx_hw_position;
			rx_sig_q  <= '0;
			tx_sig_q  <= '0;
			over_q    <= 1'b0;
		end else if (wsts.finish) begin
			if (st_q == ST_RX_WALK) begin
				rx_sig_q <= walk_sig;
			end else begin
				tx_sig_q <= walk_sig;
			end
			if (wsts.overrun) begin
				over_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_write) begin
			out_handled_q <= 1'b0;
			out_link_q    <= 1'b0;
			out_rx_sig_q  <= '0;
			out_tx_sig_q  <= '0;
			out_over_q    <= 1'b0;
			out_rx_walk_q <= rx_walk_q;
			out_tx_walk_q <= tx_walk_q;
		end else if (load_hold) begin
			out_handled_q <= handled_q;
			out_link_q    <= link_q;
			out_rx_sig_q  <= rx_sig_q;
			out_tx_sig_q  <= tx_sig_q;
			out_over_q    <= over_q;
			out_rx_walk_q <= rx_walk_q;
			out_tx_walk_q <= tx_walk_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign handled      = out_handled_q;
	assign link_changed = out_link_q;
	assign rx_signals   = out_rx_sig_q;
	assign tx_signals   = out_tx_sig_q;
	assign walk_overrun = out_over_q;

	logic [CW-1:0] rx_walk_ext, tx_walk_ext;
	assign rx_walk_ext = CW'(out_rx_walk_q);
	assign tx_walk_ext = CW'(out_tx_walk_q);
	assign rx_walk_out = rx_walk_ext[7:0];
	assign tx_walk_out = tx_walk_ext[7:0];

	drct_done_mem #(
		.DEPTH(RING_DEPTH)
	) u_mem (
		.clk     (clk),
		.wr      (mem_wr),
		.wr_addr (mem_wr_addr),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	drct_walk_unit #(
		.DEPTH(RING_DEPTH)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (wreq),
		.start_pos (wstart_pos),
		.rd_data   (mem_rd_data),
		.rd_addr   (mem_rd_addr),
		.sts       (wsts),
		.end_pos   (wend_pos),
		.steps     (wsteps)
	);

`ifndef ASSERT_OFF
	a_no_input_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CLEAR) |-> !in_ready)
		else $error("input taken during clearing pass");

	a_finish_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		wsts.finish |-> (st_q == ST_RX_WALK || st_q == ST_TX_WALK))
		else $error("walk finished outside a walk state");

	a_hold_loads: assert property (@(posedge clk) disable iff (!arst_n)
		load_hold |=> (out_valid_q && st_q == ST_IDLE))
		else $error("interrupt result not presented");

	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		load_write |=> (out_valid_q && out_rx_sig_q == 9'h0 && out_tx_sig_q == 9'h0
			&& !out_over_q))
		else $error("done-bit write result not clean");
`endif

endmodule
